@@ hdl/bhd_pkg.sv @@
// Package for the binomial half downscaler: sizes, widths, register
// indexes and the structs passed between the front and vertical stages.
// No dependencies.
package bhd_pkg;

   localparam int MAX_WIDTH      = 4096;
   localparam int MAX_HEIGHT     = 4096;
   localparam int MAX_COMPONENTS = 4;

   // one line slot per reduced column and component
   localparam int LINE_SLOTS = (MAX_WIDTH / 2) * MAX_COMPONENTS;

   localparam int CFG_W   = 13;                        // size register width
   localparam int NC_W    = 3;                         // components register width
   localparam int COL_W   = $clog2(MAX_WIDTH);         // column position
   localparam int ROW_W   = $clog2(MAX_HEIGHT);        // row position
   localparam int COMP_W  = $clog2(MAX_COMPONENTS + 1) - 1 > 0 ?
                            $clog2(MAX_COMPONENTS) : 1;
   localparam int KCOL_W  = COL_W - 1;                 // reduced column index
   localparam int ADDR_W  = $clog2(LINE_SLOTS);        // line memory address
   localparam int SAMP_W  = 8;
   localparam int QTR_W   = 10;                        // horizontal result, quarters
   localparam int ACC_W   = 12;                        // vertical partial, sixteenths
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_COMPONENTS    = 2'd2
   } csr_index_type;

   // frame geometry after clamping into the legal ranges
   typedef struct packed {
      logic [CFG_W-1:0] width;
      logic [CFG_W-1:0] height;
      logic [NC_W-1:0]  nc;
   } geom_type;

   // one horizontal result and its vertical controls
   typedef struct packed {
      logic [QTR_W-1:0]  hval;
      logic [ADDR_W-1:0] addr;
      logic              use_double;  // v = 2 * (prev + hval)
      logic              acc_we;      // write prev + 2 * hval to the accumulator
      logic              emit;        // produces an output sample
      logic              frame_last;
   } h_item_type;

endpackage

@@ hdl/bhd_if.sv @@
// Stream interfaces for the request (input sample) and response (reduced
// sample) channels. Depends on bhd_pkg.
interface bhd_req_if;
   logic                       valid;
   logic                       ready;
   logic [bhd_pkg::SAMP_W-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bhd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bhd_pkg::SAMP_W-1:0] sample_out;
   logic                       frame_last;

   modport source (output valid, output sample_out, output frame_last, input ready);
   modport sink   (input valid, input sample_out, input frame_last, output ready);
endinterface

@@ hdl/bhd_front.sv @@
// Front stage: raster position counters, held samples per component and
// the horizontal 1-2-1 pass. Depends on bhd_pkg and bhd_req_if.
module bhd_front (
   input  logic                 clock,
   input  logic                 reset,
   input  bhd_pkg::geom_type    geom,
   input  logic                 restart,
   bhd_req_if.sink              req,
   output logic                 item_valid,
   input  logic                 item_ready,
   output bhd_pkg::h_item_type  item
);

   logic [bhd_pkg::COL_W-1:0]  col_ff, col_in;
   logic [bhd_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [bhd_pkg::COMP_W-1:0] comp_ff, comp_in;

   // [7:0] newest sample, [15:8] the one before
   logic [2*bhd_pkg::SAMP_W-1:0] held_ff [bhd_pkg::MAX_COMPONENTS];

   logic                        s1_valid_ff;
   logic [bhd_pkg::SAMP_W-1:0]  s1_sample_ff, s1_p1_ff, s1_p2_ff;
   logic [bhd_pkg::COL_W-1:0]   s1_col_ff;
   logic [bhd_pkg::ROW_W-1:0]   s1_row_ff;
   logic [bhd_pkg::COMP_W-1:0]  s1_comp_ff;

   logic accept, s1_free, have_h;
   logic w_odd, h_odd, row_odd, j_zero, j_last, row_last, col_last;
   logic [bhd_pkg::CFG_W-2:0]  dw_m1, dh_m1;
   logic [bhd_pkg::KCOL_W-1:0] kcol;
   logic [bhd_pkg::ROW_W-2:0]  jrow;
   logic [bhd_pkg::QTR_W-1:0]  pair, dbl, blend;
   logic [bhd_pkg::ADDR_W-1:0] prod;

   assign accept    = req.valid && req.ready;
   assign s1_free   = !s1_valid_ff || !have_h || item_ready;
   assign req.ready = s1_free;

   // position of the next sample
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      comp_in = comp_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         comp_in = '0;
      end else if (accept) begin
         if (bhd_pkg::NC_W'(comp_ff) + 1'b1 < geom.nc) begin
            comp_in = comp_ff + 1'b1;
         end else begin
            comp_in = '0;
            if (bhd_pkg::CFG_W'(col_ff) + 1'b1 < geom.width) begin
               col_in = col_ff + 1'b1;
            end else begin
               col_in = '0;
               if (bhd_pkg::CFG_W'(row_ff) + 1'b1 < geom.height) begin
                  row_in = row_ff + 1'b1;
               end else begin
                  row_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         comp_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         comp_ff <= comp_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_free) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff[comp_ff] <= {held_ff[comp_ff][bhd_pkg::SAMP_W-1:0], req.sample_in};
         s1_sample_ff     <= req.sample_in;
         s1_p1_ff         <= held_ff[comp_ff][bhd_pkg::SAMP_W-1:0];
         s1_p2_ff         <= held_ff[comp_ff][2*bhd_pkg::SAMP_W-1:bhd_pkg::SAMP_W];
         s1_col_ff        <= col_ff;
         s1_row_ff        <= row_ff;
         s1_comp_ff       <= comp_ff;
      end
   end

   // horizontal pass, in quarters
   always_comb begin
      w_odd = geom.width[0];
      h_odd = geom.height[0];
      dw_m1 = geom.width[bhd_pkg::CFG_W-1:1] - 1'b1;
      dh_m1 = geom.height[bhd_pkg::CFG_W-1:1] - 1'b1;

      pair  = bhd_pkg::QTR_W'(s1_p1_ff) + bhd_pkg::QTR_W'(s1_sample_ff);
      dbl   = {pair[bhd_pkg::QTR_W-2:0], 1'b0};
      blend = bhd_pkg::QTR_W'(s1_p2_ff) + bhd_pkg::QTR_W'({s1_p1_ff, 1'b0})
              + bhd_pkg::QTR_W'(s1_sample_ff);

      col_last = bhd_pkg::CFG_W'(s1_col_ff) == geom.width - 1'b1;
      row_last = bhd_pkg::CFG_W'(s1_row_ff) == geom.height - 1'b1;

      have_h    = 1'b0;
      kcol      = s1_col_ff[bhd_pkg::COL_W-1:1];
      item.hval = blend;
      if (s1_col_ff[0]) begin
         have_h = !(w_odd && bhd_pkg::CFG_W'(kcol) == bhd_pkg::CFG_W'(dw_m1));
         if (kcol == '0) begin
            item.hval = dbl;
         end
      end else if (w_odd && col_last) begin
         // odd width: last output is the mean of the last two samples
         have_h    = 1'b1;
         kcol      = dw_m1[bhd_pkg::KCOL_W-1:0];
         item.hval = dbl;
      end

      prod      = bhd_pkg::ADDR_W'(kcol) * bhd_pkg::ADDR_W'(geom.nc)
                  + bhd_pkg::ADDR_W'(s1_comp_ff);
      item.addr = prod;

      // vertical controls
      row_odd = s1_row_ff[0];
      jrow    = s1_row_ff[bhd_pkg::ROW_W-1:1];
      j_zero  = jrow == '0;
      j_last  = h_odd && bhd_pkg::CFG_W'(jrow) == bhd_pkg::CFG_W'(dh_m1);

      item.use_double = !row_odd || j_zero;
      item.acc_we     = !row_odd && !j_zero;
      item.emit       = row_odd ? !j_last : (h_odd && row_last);
      item.frame_last = row_last && col_last
                        && bhd_pkg::NC_W'(s1_comp_ff) == geom.nc - 1'b1;
   end

   assign item_valid = s1_valid_ff && have_h;

`ifndef NO_ASSERTIONS
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      bhd_pkg::CFG_W'(col_ff) < geom.width)
      else $error("column position beyond frame width");

   a_comp_in_pixel: assert property (@(posedge clock) disable iff (reset)
      bhd_pkg::NC_W'(comp_ff) < geom.nc)
      else $error("component position beyond component count");

   a_last_is_emitted: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && item.frame_last |-> have_h && item.emit)
      else $error("final sample of frame would not produce a result");
`endif

endmodule

@@ hdl/bhd_vert.sv @@
// Vertical stage: line memories for the previous row and partial sums,
// vertical blend, rounding and the result register. Depends on bhd_pkg
// and bhd_rsp_if.
module bhd_vert (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  bhd_pkg::h_item_type  item,
   bhd_rsp_if.source            rsp
);

   logic [bhd_pkg::QTR_W-1:0] prev_mem [bhd_pkg::LINE_SLOTS];
   logic [bhd_pkg::ACC_W-1:0] acc_mem  [bhd_pkg::LINE_SLOTS];

   logic                      s2_valid_ff;
   bhd_pkg::h_item_type       s2_item_ff;
   logic [bhd_pkg::QTR_W-1:0] prev_rd_ff;
   logic [bhd_pkg::ACC_W-1:0] acc_rd_ff;

   logic                       rsp_valid_ff;
   logic [bhd_pkg::SAMP_W-1:0] sample_ff;
   logic                       last_ff;

   logic out_free, s2_move, load_s2, fwd;
   logic [bhd_pkg::QTR_W:0]    col_sum;
   logic [bhd_pkg::ACC_W-1:0]  v_sum;
   logic [bhd_pkg::ACC_W-1:0]  v, acc_wr;
   logic [bhd_pkg::ACC_W:0]    rnd;
   logic [bhd_pkg::SAMP_W-1:0] rounded;

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign s2_move    = s2_valid_ff && (!s2_item_ff.emit || out_free);
   assign item_ready = !s2_valid_ff || s2_move;
   assign load_s2    = item_valid && item_ready;
   // one slot per row (1 reduced column, 1 component): the slot being
   // written is the one being read, so take the new values directly
   assign fwd        = s2_move && item.addr == s2_item_ff.addr;

   always_comb begin
      col_sum = {1'b0, prev_rd_ff} + {1'b0, s2_item_ff.hval};
      v_sum   = acc_rd_ff + bhd_pkg::ACC_W'(s2_item_ff.hval);
      v       = s2_item_ff.use_double ? {col_sum, 1'b0} : v_sum;
      acc_wr  = bhd_pkg::ACC_W'(prev_rd_ff) + bhd_pkg::ACC_W'({s2_item_ff.hval, 1'b0});
      rnd     = {1'b0, v} + (bhd_pkg::ACC_W+1)'(8);
      rounded = rnd[bhd_pkg::ACC_W] ? '1 : rnd[bhd_pkg::ACC_W-1:4];
   end

   // line memories: one read on load, one write as the item leaves
   always_ff @(posedge clock) begin
      if (load_s2) begin
         if (fwd) begin
            prev_rd_ff <= s2_item_ff.hval;
         end else begin
            prev_rd_ff <= prev_mem[item.addr];
         end
         if (fwd && s2_item_ff.acc_we) begin
            acc_rd_ff <= acc_wr;
         end else begin
            acc_rd_ff <= acc_mem[item.addr];
         end
         s2_item_ff <= item;
      end
      if (s2_move) begin
         prev_mem[s2_item_ff.addr] <= s2_item_ff.hval;
         if (s2_item_ff.acc_we) begin
            acc_mem[s2_item_ff.addr] <= acc_wr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_s2) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_move) begin
            s2_valid_ff <= 1'b0;
         end
         if (s2_move && s2_item_ff.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_move && s2_item_ff.emit) begin
         sample_ff <= rounded;
         last_ff   <= s2_item_ff.frame_last;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = sample_ff;
   assign rsp.frame_last = last_ff;

`ifndef NO_ASSERTIONS
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready
      |=> rsp_valid_ff && $stable(sample_ff) && $stable(last_ff))
      else $error("stalled result changed or dropped");

   a_result_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_valid_ff && s2_item_ff.emit))
      else $error("result raised without an emitting item");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_item_ff.emit && !out_free
      |=> s2_valid_ff && $stable(s2_item_ff.addr))
      else $error("stalled item lost from vertical stage");
`endif

endmodule

@@ hdl/binomial_half_downscale.sv @@
// Binomial half downscaler (1-2-1 pyramid reduce), top level.
// Depends on bhd_pkg, bhd_req_if/bhd_rsp_if, bhd_front and bhd_vert.
//
// Usage:
//  - req_chan carries 8-bit component samples in raster order, components
//    interleaved; rsp_chan returns the reduced frame (half width, half height)
//    in raster order, frame_last set on its final sample.
//  - While rsp_chan accepts, one transaction on req_chan is taken every cycle;
//    a completing sample gives one rsp_chan transaction, others give none.
//  - A result passes the front register, the line memory read register and
//    the result register before it appears on rsp_chan.
//  - Throughput when rsp_chan accepts: one sample per clock, set by the single
//    read and single write port of each line memory (one access pair each).
//  - A rsp_chan stall holds the result register; the vertical stage and the
//    front register keep filling behind it, so req_chan stalls only once both
//    are occupied.
//  - csr_* writes set width, height and component count; any write (also to
//    an unused index) restarts the frame. Write only while the block is idle.
//  - Reset: synchronous; clears positions and pipeline valids, loads 640 x 480,
//    3 components. Line memories need no clearing: each slot is written first.
module binomial_half_downscale (
   input  logic                             clock,
   input  logic                             reset,
   bhd_req_if.sink                          req_chan,
   bhd_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [bhd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bhd_pkg::CFG_W-1:0]        csr_wdata
);

   logic [bhd_pkg::CFG_W-1:0] width_ff, height_ff;
   logic [bhd_pkg::NC_W-1:0]  nc_ff;

   bhd_pkg::geom_type   geom;
   bhd_pkg::h_item_type item;
   logic                item_valid, item_ready;

   // configuration registers, raw as written
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bhd_pkg::CFG_W'(640);
         height_ff <= bhd_pkg::CFG_W'(480);
         nc_ff     <= bhd_pkg::NC_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            bhd_pkg::CSR_SOURCE_WIDTH:  width_ff  <= csr_wdata;
            bhd_pkg::CSR_SOURCE_HEIGHT: height_ff <= csr_wdata;
            bhd_pkg::CSR_COMPONENTS:    nc_ff     <= csr_wdata[bhd_pkg::NC_W-1:0];
            default: ;  // unused index: restart only
         endcase
      end
   end

   // saturate sizes into the supported ranges
   always_comb begin
      if (width_ff < bhd_pkg::CFG_W'(2)) begin
         geom.width = bhd_pkg::CFG_W'(2);
      end else if (width_ff > bhd_pkg::CFG_W'(bhd_pkg::MAX_WIDTH)) begin
         geom.width = bhd_pkg::CFG_W'(bhd_pkg::MAX_WIDTH);
      end else begin
         geom.width = width_ff;
      end

      if (height_ff < bhd_pkg::CFG_W'(2)) begin
         geom.height = bhd_pkg::CFG_W'(2);
      end else if (height_ff > bhd_pkg::CFG_W'(bhd_pkg::MAX_HEIGHT)) begin
         geom.height = bhd_pkg::CFG_W'(bhd_pkg::MAX_HEIGHT);
      end else begin
         geom.height = height_ff;
      end

      if (nc_ff == '0) begin
         geom.nc = bhd_pkg::NC_W'(1);
      end else if (nc_ff > bhd_pkg::NC_W'(bhd_pkg::MAX_COMPONENTS)) begin
         geom.nc = bhd_pkg::NC_W'(bhd_pkg::MAX_COMPONENTS);
      end else begin
         geom.nc = nc_ff;
      end
   end

   // positions, held samples, horizontal blend
   bhd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom),
      .restart    (csr_we),
      .req        (req_chan),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   // line memories, vertical blend, rounding, result register
   bhd_vert u_vert (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp        (rsp_chan)
   );

endmodule

@@ test/tb_binomial_half_downscale.sv @@
// Self-checking testbench for binomial_half_downscale: random and directed frames,
// predicted in-bench and compared per reduced sample.
// Depends on bhd_pkg, bhd_req_if/bhd_rsp_if and the RTL top level.
module tb_binomial_half_downscale;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int DRAIN_CYCLES    = 8;     // margin for the block to retire items after draining
   localparam int IDLE_LIMIT      = 5000;  // cycles with no transaction before giving up
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall in the pressure test
   localparam int RANDOM_ITEMS    = 1250;
   localparam int RESET_ITEMS     = 200;   // start of row 0 in the reset geometry

   // index past the register list: restarts the frame, changes nothing
   localparam logic [bhd_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_mode_type;

   typedef struct packed {
      logic [bhd_pkg::SAMP_W-1:0] sample;
      logic                       last;
   } reduced_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_we    = 1'b0;
   logic [bhd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bhd_pkg::CFG_W-1:0]     csr_wdata = '0;

   bhd_req_if req_bus();
   bhd_rsp_if rsp_bus();

   binomial_half_downscale dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the registers, positions and line stores
   // ---------------------------------------------------------------------
   logic [bhd_pkg::CFG_W-1:0]  width_reg  = 13'd640;
   logic [bhd_pkg::CFG_W-1:0]  height_reg = 13'd480;
   logic [bhd_pkg::NC_W-1:0]   comps_reg  = 3'd3;

   logic [bhd_pkg::COL_W-1:0]  col_pos  = '0;
   logic [bhd_pkg::ROW_W-1:0]  row_pos  = '0;
   logic [bhd_pkg::COMP_W-1:0] comp_pos = '0;

   // last two samples per component
   logic [bhd_pkg::SAMP_W-1:0] held [bhd_pkg::MAX_COMPONENTS*2];
   // partial vertical sum, sixteenths
   logic [bhd_pkg::ACC_W-1:0]  row_acc   [bhd_pkg::LINE_SLOTS];
   // prior row horizontal result, quarters
   logic [bhd_pkg::QTR_W-1:0]  prev_line [bhd_pkg::LINE_SLOTS];

   reduced_type expected_samples [$];

   // run statistics and verdict
   int failures        = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int geometries      = 0;

   // flow control knobs (percent) and the receiver hold-off
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_cycles = 0;

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned frame_size(input int unsigned w, input int unsigned h,
                                              input int unsigned nc);
      return clamp_size(w[bhd_pkg::CFG_W-1:0], 2, bhd_pkg::MAX_WIDTH)
             * clamp_size(h[bhd_pkg::CFG_W-1:0], 2, bhd_pkg::MAX_HEIGHT)
             * clamp_size(nc[bhd_pkg::NC_W-1:0], 1, bhd_pkg::MAX_COMPONENTS);
   endfunction

   function automatic void restart_position();
      col_pos  = '0;
      row_pos  = '0;
      comp_pos = '0;
   endfunction

   // One accepted input sample: update the predicted state and queue the
   // reduced sample it completes, if any.
   function automatic void reduce_sample(input logic [bhd_pkg::SAMP_W-1:0] s);
      int unsigned w, h, nc, dw, dh, col, row, comp, p1, p2, k, j, hval, v, m, pv, r;
      bit have_h, emit;
      reduced_type res;
      w  = clamp_size(width_reg, 2, bhd_pkg::MAX_WIDTH);
      h  = clamp_size(height_reg, 2, bhd_pkg::MAX_HEIGHT);
      nc = clamp_size(comps_reg, 1, bhd_pkg::MAX_COMPONENTS);
      dw = w / 2;
      dh = h / 2;
      have_h = 1'b0;
      emit   = 1'b0;
      k = 0;
      hval = 0;
      v = 0;

      if (col_pos >= w || row_pos >= h || comp_pos >= nc)
         restart_position();
      col  = col_pos;
      row  = row_pos;
      comp = comp_pos;
      p1 = held[comp*2];
      p2 = held[comp*2+1];

      // horizontal: quarters; odd width folds the last pair into a mean
      if (col[0]) begin
         k = (col - 1) / 2;
         if (k < dw && !(w[0] && k == dw - 1)) begin
            hval = (k == 0) ? 2 * (p1 + s) : p2 + 2 * p1 + s;
            have_h = 1'b1;
         end
      end else if (w[0] && col == w - 1) begin
         k = dw - 1;
         hval = 2 * (p1 + s);
         have_h = 1'b1;
      end
      held[comp*2+1] = p1[bhd_pkg::SAMP_W-1:0];
      held[comp*2]   = s;

      // vertical: sixteenths, same edge rules along the rows
      if (have_h) begin
         m  = k * nc + comp;
         pv = prev_line[m];
         if (row[0]) begin
            j = (row - 1) / 2;
            if (j < dh && !(h[0] && j == dh - 1)) begin
               v = (j == 0) ? 2 * (pv + hval) : row_acc[m] + hval;
               emit = 1'b1;
            end
         end else begin
            if (row >= 2)
               row_acc[m] = bhd_pkg::ACC_W'(pv + 2 * hval);
            if (h[0] && row == h - 1) begin
               v = 2 * (pv + hval);
               emit = 1'b1;
            end
         end
         prev_line[m] = bhd_pkg::QTR_W'(hval);
      end

      if (emit) begin
         r = (v + 8) >> 4;
         if (r > 255) r = 255;
         res.sample = r[bhd_pkg::SAMP_W-1:0];
         res.last   = (row == h - 1 && col == w - 1 && comp == nc - 1);
         expected_samples.push_back(res);
      end

      if (comp + 1 < nc) begin
         comp_pos = bhd_pkg::COMP_W'(comp + 1);
      end else begin
         comp_pos = '0;
         if (col + 1 < w) begin
            col_pos = bhd_pkg::COL_W'(col + 1);
         end else begin
            col_pos = '0;
            row_pos = (row + 1 < h) ? bhd_pkg::ROW_W'(row + 1) : '0;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Result checker: every transaction on rsp_bus against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected result: sample_out %0d frame_last %0b",
                   rsp_bus.sample_out, rsp_bus.frame_last);
            failures++;
         end else begin
            reduced_type exp_res;
            exp_res = expected_samples.pop_front();
            if (rsp_bus.sample_out !== exp_res.sample) begin
               $error("sample_out: expected %0d, got %0d", exp_res.sample, rsp_bus.sample_out);
               failures++;
            end
            if (rsp_bus.frame_last !== exp_res.last) begin
               $error("frame_last: expected %0b, got %0b", exp_res.last, rsp_bus.frame_last);
               failures++;
            end
            results_checked++;
         end
      end
   end

   // Watchdog: too long without any transaction on either side
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_samples.size());
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Shared driving tasks
   // ---------------------------------------------------------------------
   task automatic set_flow(input flow_mode_type mode);
      case (mode)
         FLOW_FREE:      begin idle_pct = 0;  stall_pct = 0;  end
         FLOW_SRC_IDLE:  begin idle_pct = 55; stall_pct = 0;  end
         FLOW_SNK_STALL: begin idle_pct = 0;  stall_pct = 55; end
         default:        begin idle_pct = 14; stall_pct = 14; end
      endcase
   endtask

   // Offer one sample; returns at the edge that accepts it.
   task automatic push_sample(input logic [bhd_pkg::SAMP_W-1:0] s);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      reduce_sample(s);
      items_sent++;
   endtask

   // Random content, weighted towards the extremes now and then
   task automatic send_samples(input int unsigned n);
      int unsigned pick;
      for (int unsigned i = 0; i < n; i++) begin
         pick = $urandom_range(9);
         if (pick == 0)      push_sample(8'd0);
         else if (pick == 1) push_sample(8'd255);
         else                push_sample(bhd_pkg::SAMP_W'($urandom_range(255)));
      end
   endtask

   // Sender pause until every outstanding result is back. Always waits on the
   // clock before it checks, so valid is never lowered and raised in one step.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_samples.size() != 0);
   endtask

   // Idle point for register writes: drained, then the pipeline given time
   // to retire samples that produce no result.
   task automatic wait_idle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [bhd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bhd_pkg::CFG_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         bhd_pkg::CSR_SOURCE_WIDTH:  width_reg  = data;
         bhd_pkg::CSR_SOURCE_HEIGHT: height_reg = data;
         bhd_pkg::CSR_COMPONENTS:    comps_reg  = data[bhd_pkg::NC_W-1:0];
         default: ;
      endcase
      restart_position();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // New geometry; junk in the upper component bits, which the block drops
   task automatic configure(input int unsigned w, input int unsigned h, input int unsigned nc);
      wait_idle();
      write_reg(bhd_pkg::CSR_SOURCE_WIDTH, w[bhd_pkg::CFG_W-1:0]);
      write_reg(bhd_pkg::CSR_SOURCE_HEIGHT, h[bhd_pkg::CFG_W-1:0]);
      write_reg(bhd_pkg::CSR_COMPONENTS,
                {(bhd_pkg::CFG_W-bhd_pkg::NC_W)'($urandom), nc[bhd_pkg::NC_W-1:0]});
      geometries++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset geometry 640 x 480, 3 components: the start of row 0 is taken
   // and must give no reduced sample yet
   task automatic test_reset_geometry();
      set_flow(FLOW_SNK_STALL);
      geometries++;
      send_samples(RESET_ITEMS);
   endtask

   // Rounding, saturation-free extremes, odd sizes and clamped register values
   task automatic test_directed();
      set_flow(FLOW_FREE);
      configure(2, 2, 1);
      repeat (4) push_sample(8'd255);           // all-high block stays at full scale
      push_sample(8'd0); push_sample(8'd1);     // mean exactly one half: rounds up
      push_sample(8'd0); push_sample(8'd1);
      push_sample(8'd0); push_sample(8'd0);     // one quarter: rounds down
      push_sample(8'd0); push_sample(8'd1);
      configure(3, 3, 1);                       // odd on both axes
      send_samples(9);
      configure(1, 0, 0);                       // below range: acts as 2 x 2, one component
      send_samples(4);
   endtask

   // Many small random geometries, cycling the flow modes; some frames cut short
   task automatic test_random_geometries();
      int unsigned w, h, nc, sz, n, phase, sent;
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         w  = ($urandom_range(7) == 0) ? $urandom_range(40, 2) : $urandom_range(12, 0);
         h  = $urandom_range(8, 0);
         nc = $urandom_range(7, 0);
         set_flow(flow_mode_type'(phase % 4));
         configure(w, h, nc);
         sz = frame_size(w, h, nc);
         n  = sz * $urandom_range(2, 1);
         if ($urandom_range(3) == 0)
            n = n + $urandom_range(sz - 1, 1);  // partial frame, restarted by the next write
         if (n > RANDOM_ITEMS - sent)
            n = RANDOM_ITEMS - sent;
         send_samples(n);
         sent  = sent + n;
         phase = phase + 1;
      end
   endtask

   // Long receiver hold-off while the sender keeps offering, then a sender
   // pause mid-frame until everything has come back
   task automatic test_backpressure();
      set_flow(FLOW_FREE);
      configure(16, 6, 2);
      send_samples(48);
      hold_cycles = HOLD_OFF_CYCLES;
      send_samples(72);
      wait_drained();
      send_samples(frame_size(16, 6, 2) - 120);
   endtask

   // A write to an index past the list restarts the frame mid-way, registers kept
   task automatic test_unused_index();
      set_flow(FLOW_BOTH);
      configure(6, 4, 2);
      send_samples(30);
      wait_idle();
      write_reg(CSR_UNUSED_INDEX, bhd_pkg::CFG_W'($urandom));
      send_samples(frame_size(6, 4, 2));
   endtask

   // Register values above range: start of a tall frame (height from 8191)
   // and of a wide one (width and components above range)
   task automatic test_size_extremes();
      set_flow(FLOW_FREE);
      configure(2, 8191, 1);
      send_samples(64);
      set_flow(FLOW_BOTH);
      configure(8191, 3, 7);
      send_samples(96);
   endtask

   initial begin
      req_bus.valid     = 1'b0;
      req_bus.sample_in = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_geometry();
      test_directed();
      test_random_geometries();
      test_backpressure();
      test_unused_index();
      test_size_extremes();

      wait_idle();
      $display("run covered %0d input transactions over %0d geometries, %0d reduced samples",
               items_sent, geometries, results_checked);
      $display("with odd and clamped sizes, all flow modes, a long hold-off and restart writes");
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
